/* src/blb_pkg.sv */
// ----------------------------------------------------------------------------
// blb_pkg
// Shared types and constants of the bin load balancer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blb_pkg;

    // stream payload layout
    localparam int CAND_W      = 10;
    localparam int WEIGHT_W    = 8;
    localparam int NUM_CAND    = 4;
    localparam int OUT_LOAD_W  = 24;
    localparam int IN_TDATA_W  = NUM_CAND * CAND_W + WEIGHT_W;
    localparam int OUT_USED_W  = CAND_W + 4 * OUT_LOAD_W + 1;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    // output field offsets
    localparam int OFS_NEW_LOAD = CAND_W;
    localparam int OFS_HIGHEST  = OFS_NEW_LOAD + OUT_LOAD_W;
    localparam int OFS_LOWEST   = OFS_HIGHEST + OUT_LOAD_W;
    localparam int OFS_GAP      = OFS_LOWEST + OUT_LOAD_W;
    localparam int OFS_SAT      = OFS_GAP + OUT_LOAD_W;

    // register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_BINS_LOG2 = 2'd1,
        REG_CHOICES   = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    localparam logic [1:0] MODE_RANDOM    = 2'd0;
    localparam logic [1:0] MODE_BEST_OF_D = 2'd1;
    localparam logic [1:0] MODE_MIN_LOAD  = 2'd2;

    localparam logic [1:0] RST_MODE      = MODE_BEST_OF_D;
    localparam logic [3:0] RST_BINS_LOG2 = 4'd4;
    localparam logic [2:0] RST_CHOICES   = 3'd2;

    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_CHOOSE = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_STATS  = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

endpackage

/* src/blb_ram.sv */
// ----------------------------------------------------------------------------
// blb_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bin_load_balancer_unit.sv */
// ----------------------------------------------------------------------------
// bin_load_balancer_unit
// Place item: scans the n active bins (one RAM read per cycle), then steps over
//   c choices (c the effective num_choices in best-of-d mode, else 1), writes the
//   new load and updates the statistics; clear item: zeroes all MAX_BINS loads.
// One item at a time, tready only while idle.
// Reset (synchronous, active low) restores the registers, then sweeps the load
//   RAM to zero before the first item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bin_load_balancer_unit #(
    parameter int MAX_BINS    = 1024,
    parameter int MAX_CHOICES = 4,
    parameter int LOAD_BITS   = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // apb register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [blb_pkg::PADDR_W-1:0]        paddr,
    input  logic [blb_pkg::PDATA_W-1:0]        pwdata,
    output logic [blb_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // candidate_a, candidate_b, candidate_c, candidate_d, ball_weight
    input  logic [blb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // chosen_bin, new_load, highest_load, lowest_load, load_gap, saturated
    output logic [blb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import blb_pkg::*;

    localparam int AW         = $clog2(MAX_BINS);
    localparam int LG_MAX     = $clog2(MAX_BINS + 1) - 1;
    localparam int CHOICE_LIM = (MAX_CHOICES < NUM_CAND) ? MAX_CHOICES : NUM_CAND;
    localparam int KW         = (CHOICE_LIM > 1) ? $clog2(CHOICE_LIM) : 1;
    localparam logic [AW-1:0]        CLR_LAST = AW'(MAX_BINS - 1);
    localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

    t_state r_state, n_state;

    // configuration
    logic [1:0] r_mode;
    logic [3:0] r_bins_log2;
    logic [2:0] r_num_choices;

    // job
    logic [AW-1:0]       r_cand [CHOICE_LIM];
    logic [WEIGHT_W-1:0] r_weight;
    logic [1:0]          r_job_mode;
    logic [KW-1:0]       r_dlast;
    logic [AW-1:0]       r_last;
    logic                r_boot;

    // scan
    logic [AW-1:0]        r_cnt;
    logic                 r_issue;
    logic                 r_rd_v;
    logic [AW-1:0]        r_rd_idx;
    logic [LOAD_BITS-1:0] r_hi;
    logic [LOAD_BITS-1:0] r_lo;
    logic [LOAD_BITS-1:0] r_min1;
    logic [LOAD_BITS-1:0] r_min2;
    logic [AW-1:0]        r_idx1;
    logic [LOAD_BITS-1:0] r_cl [CHOICE_LIM];

    // choice and update
    logic [KW-1:0]        r_k;
    logic [LOAD_BITS-1:0] r_best;
    logic [AW-1:0]        r_bin;
    logic [LOAD_BITS-1:0] r_newload;
    logic                 r_sat;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                 cfg_wr;
    logic                 in_xfer;
    logic                 out_free;
    logic [3:0]           lg_sel;
    logic [AW-1:0]        act_mask;
    logic [2:0]           d_sel;
    logic [AW-1:0]        cand_in [CHOICE_LIM];
    logic [LOAD_BITS:0]   sum;
    logic [LOAD_BITS-1:0] upd_load;
    logic [LOAD_BITS-1:0] hi_new;
    logic [LOAD_BITS-1:0] lo_excl;
    logic [LOAD_BITS-1:0] lo_new;
    logic [LOAD_BITS-1:0] gap;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [LOAD_BITS-1:0] ram_wdata;
    logic [LOAD_BITS-1:0] ram_rdata;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= RST_MODE;
            r_bins_log2   <= RST_BINS_LOG2;
            r_num_choices <= RST_CHOICES;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_MODE:      r_mode        <= pwdata[1:0];
                REG_BINS_LOG2: r_bins_log2   <= pwdata[3:0];
                REG_CHOICES:   r_num_choices <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_MODE:      prdata = {{(PDATA_W - 2){1'b0}}, r_mode};
            REG_BINS_LOG2: prdata = {{(PDATA_W - 4){1'b0}}, r_bins_log2};
            REG_CHOICES:   prdata = {{(PDATA_W - 3){1'b0}}, r_num_choices};
            default:       prdata = '0;
        endcase
    end

    // ---------------- job setup ----------------
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        lg_sel = (r_bins_log2 == 4'd0) ? 4'd1 : r_bins_log2;
        if (lg_sel > 4'(LG_MAX)) begin
            lg_sel = 4'(LG_MAX);
        end
        for (int j = 0; j < AW; j++) begin
            act_mask[j] = (j < int'(lg_sel));
        end
        d_sel = (r_num_choices == 3'd0) ? 3'd1 : r_num_choices;
        if (d_sel > 3'(CHOICE_LIM)) begin
            d_sel = 3'(CHOICE_LIM);
        end
        for (int k = 0; k < CHOICE_LIM; k++) begin
            cand_in[k] = AW'(s_axis_tdata[k*CAND_W +: CAND_W]) & act_mask;
        end
    end

    // ---------------- update and statistics ----------------
    always_comb begin
        sum      = {1'b0, r_best} + (LOAD_BITS + 1)'(r_weight);
        upd_load = sum[LOAD_BITS] ? LOAD_MAX : sum[LOAD_BITS-1:0];
        hi_new   = (r_newload > r_hi) ? r_newload : r_hi;
        // the chosen bin only grew, so the low mark is the minimum over the others
        lo_excl  = (r_bin == r_idx1) ? r_min2 : r_min1;
        lo_new   = (r_newload < lo_excl) ? r_newload : lo_excl;
        gap      = r_hi - r_lo;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_cnt == CLR_LAST) begin
                    n_state = r_boot ? S_IDLE : S_RESULT;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (s_axis_tuser == KIND_CLEAR) ? S_CLEAR : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_v && (r_rd_idx == r_last)) begin
                    n_state = S_CHOOSE;
                end
            end
            S_CHOOSE: begin
                if (r_k == r_dlast) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_STATS;
            S_STATS:  n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_boot  <= 1'b1;
            r_cnt   <= '0;
            r_issue <= 1'b0;
            r_rd_v  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CLR_LAST) begin
                        r_boot <= 1'b0;
                    end
                end
                S_IDLE: begin
                    r_cnt   <= '0;
                    r_issue <= 1'b1;
                    r_rd_v  <= 1'b0;
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (r_cnt == r_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    r_rd_v <= r_issue;
                    r_k    <= '0;
                end
                S_CHOOSE: begin
                    r_k <= r_k + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload side of the sequencer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CLEAR: begin
                r_bin     <= '0;
                r_newload <= '0;
                r_sat     <= 1'b0;
                r_hi      <= '0;
                r_lo      <= '0;
            end
            S_IDLE: begin
                for (int k = 0; k < CHOICE_LIM; k++) begin
                    r_cand[k] <= cand_in[k];
                end
                r_weight   <= s_axis_tdata[NUM_CAND*CAND_W +: WEIGHT_W];
                r_job_mode <= r_mode;
                r_dlast    <= (r_mode == MODE_BEST_OF_D) ? KW'(d_sel - 3'd1) : '0;
                r_last     <= act_mask;
            end
            S_SCAN: begin
                r_rd_idx <= r_cnt;
                if (r_rd_v) begin
                    if (r_rd_idx == '0) begin
                        r_hi   <= ram_rdata;
                        r_min1 <= ram_rdata;
                        r_idx1 <= '0;
                        r_min2 <= LOAD_MAX;
                    end else begin
                        if (ram_rdata > r_hi) begin
                            r_hi <= ram_rdata;
                        end
                        if (ram_rdata < r_min1) begin
                            r_min2 <= r_min1;
                            r_min1 <= ram_rdata;
                            r_idx1 <= r_rd_idx;
                        end else if (ram_rdata < r_min2) begin
                            r_min2 <= ram_rdata;
                        end
                    end
                    for (int k = 0; k < CHOICE_LIM; k++) begin
                        if (r_rd_idx == r_cand[k]) begin
                            r_cl[k] <= ram_rdata;
                        end
                    end
                end
            end
            S_CHOOSE: begin
                if (r_k == '0) begin
                    if (r_job_mode == MODE_MIN_LOAD) begin
                        r_best <= r_min1;
                        r_bin  <= r_idx1;
                    end else begin
                        r_best <= r_cl[0];
                        r_bin  <= r_cand[0];
                    end
                end else if (r_cl[r_k] < r_best) begin
                    r_best <= r_cl[r_k];
                    r_bin  <= r_cand[r_k];
                end
            end
            S_UPDATE: begin
                r_newload <= upd_load;
                r_sat     <= sum[LOAD_BITS];
            end
            S_STATS: begin
                r_hi <= hi_new;
                r_lo <= lo_new;
            end
            default: ;
        endcase
    end

    // ---------------- load table ----------------
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_UPDATE);
    assign ram_addr  = (r_state == S_UPDATE) ? r_bin : r_cnt;
    assign ram_wdata = (r_state == S_UPDATE) ? upd_load : '0;

    blb_ram #(
        .WIDTH (LOAD_BITS),
        .DEPTH (MAX_BINS)
    ) u_loads (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RESULT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESULT) && out_free) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, r_sat,
                           OUT_LOAD_W'(gap), OUT_LOAD_W'(r_lo),
                           OUT_LOAD_W'(r_hi), OUT_LOAD_W'(r_newload),
                           CAND_W'(r_bin)};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* src/blb_checker.sv */
// ----------------------------------------------------------------------------
// blb_checker
// Port-level checks of the bin load balancer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [blb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import blb_pkg::*;

    logic [OUT_LOAD_W-1:0] f_new;
    logic [OUT_LOAD_W-1:0] f_hi;
    logic [OUT_LOAD_W-1:0] f_lo;
    logic [OUT_LOAD_W-1:0] f_gap;
    logic                  f_sat;

    assign f_new = m_axis_tdata[OFS_NEW_LOAD +: OUT_LOAD_W];
    assign f_hi  = m_axis_tdata[OFS_HIGHEST +: OUT_LOAD_W];
    assign f_lo  = m_axis_tdata[OFS_LOWEST +: OUT_LOAD_W];
    assign f_gap = m_axis_tdata[OFS_GAP +: OUT_LOAD_W];
    assign f_sat = m_axis_tdata[OFS_SAT];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (f_gap == OUT_LOAD_W'(f_hi - f_lo)))
        else $error("load gap does not match highest minus lowest");

    a_sat_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && f_sat |-> (f_new == f_hi))
        else $error("saturated bin is not the highest load");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new item taken while one is in progress");

endmodule

bind bin_load_balancer_unit blb_checker u_blb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
